// ===== design/dfrq_pkg.sv =====
// dfrq_pkg: shared types and constants for the display frame ring queue.
// Used by dfrq_flag_mem and display_frame_ring_queue; no dependencies.
package dfrq_pkg;

	localparam int PIC_W     = 5;
	localparam int PIC_SLOTS = 32;
	localparam int CNT_W     = 6;

	localparam logic [CNT_W-1:0] DEPTH_RESET = 6'd32;

	typedef enum logic [1:0] {
		ACT_ENQ   = 2'd0,
		ACT_DEQ   = 2'd1,
		ACT_DROP  = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PIC_FREE   = 2'd0,
		PIC_QUEUED = 2'd1,
		PIC_SHOWN  = 2'd2
	} pic_state_t;

	typedef struct packed {
		logic             clear;
		logic             re;
		logic [PIC_W-1:0] raddr;
		logic             we;
		logic [PIC_W-1:0] waddr;
		pic_state_t       wdata;
	} flag_req_t;

endpackage

// ===== design/dfrq_ring_mem.sv =====
// dfrq_ring_mem: ring entry store, one write port and one registered read port.
// Generic; no package dependencies.
module dfrq_ring_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 37
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/dfrq_flag_mem.sv =====
// dfrq_flag_mem: per-picture state store with valid bits; invalid reads as free.
// Depends on dfrq_pkg.
module dfrq_flag_mem (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dfrq_pkg::flag_req_t    req,
	output dfrq_pkg::pic_state_t   rdata
);

	dfrq_pkg::pic_state_t              mem [dfrq_pkg::PIC_SLOTS];
	logic [dfrq_pkg::PIC_SLOTS-1:0]    vld_q;
	dfrq_pkg::pic_state_t              rd_q;
	logic                              rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clear) begin
				vld_q <= '0;
			end else if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rd_vld_q <= vld_q[req.raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : dfrq_pkg::PIC_FREE;

endmodule

// ===== design/display_frame_ring_queue.sv =====
// display_frame_ring_queue: ring queue of display entries with per-picture state.
// Each beat is registered in idle as the memory reads start; exec then does
// the read-modify-write and registers the result (drop-until goes on in the
// walk state). One item in flight: no beat is taken till the last is done.
// Drop-until pops one entry per cycle while the output is free.
// Reset and any depth write: queue empty, all pictures free; reset depth is 32.
module display_frame_ring_queue #(
	parameter int MAX_DEPTH    = 32,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dfrq_pkg::CNT_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        action,
	input  logic [dfrq_pkg::PIC_W-1:0]        pic_index,
	input  logic [PAYLOAD_BITS-1:0]           payload,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [dfrq_pkg::PIC_W-1:0]        out_picture_index,
	output logic [PAYLOAD_BITS-1:0]           out_payload,
	output logic [1:0]                        picture_state,
	output logic [dfrq_pkg::CNT_W-1:0]        frames_in_queue,
	output logic [dfrq_pkg::CNT_W-1:0]        dropped_count
);

	localparam int CW = dfrq_pkg::CNT_W;
	localparam int PW = dfrq_pkg::PIC_W;
	localparam int AW = $clog2(MAX_DEPTH);
	localparam int RW = PW + PAYLOAD_BITS;
	localparam logic [CW-1:0] MAX_CLAMP = (MAX_DEPTH > ((1 << CW) - 1)) ?
		{CW{1'b1}} : CW'(MAX_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_WALK = 3'b100
	} fsm_t;

	fsm_t                    state_q, state_d;
	dfrq_pkg::action_t       act_q;
	logic [PW-1:0]           pic_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [CW-1:0]           depth_q;
	logic [CW-1:0]           rp_q, rp_d;
	logic [CW-1:0]           cnt_q, cnt_d;
	logic [CW-1:0]           drop_q, drop_d;

	logic                    out_valid_q;
	dfrq_pkg::status_t       status_q, status_d;
	logic [PW-1:0]           opic_q, opic_d;
	logic [PAYLOAD_BITS-1:0] opay_q, opay_d;
	dfrq_pkg::pic_state_t    ostate_q, ostate_d;
	logic [CW-1:0]           frames_q;
	logic [CW-1:0]           dropped_q;

	logic                    in_fire, cfg_fire, out_free, fin;
	logic [CW-1:0]           live;
	logic                    pic_ok;
	logic [CW:0]             wsum, rp_inc;
	logic [CW-1:0]           wa, rp_next;

	logic                    ring_we, ring_re;
	logic [AW-1:0]           ring_raddr;
	logic [RW-1:0]           ring_rdata;
	logic [PW-1:0]           ring_rd_pic;
	dfrq_pkg::flag_req_t     flag_req;
	dfrq_pkg::pic_state_t    flag_rdata;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign in_fire   = in_valid && in_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		if (depth_q == '0) begin
			live = CW'(1);
		end else if (depth_q > MAX_CLAMP) begin
			live = MAX_CLAMP;
		end else begin
			live = depth_q;
		end
	end

	assign pic_ok      = {1'b0, pic_q} < live;
	assign wsum        = {1'b0, rp_q} + {1'b0, cnt_q};
	assign wa          = (wsum >= {1'b0, live}) ? CW'(wsum - {1'b0, live}) : CW'(wsum);
	assign rp_inc      = {1'b0, rp_q} + (CW+1)'(1);
	assign rp_next     = (rp_inc == {1'b0, live}) ? '0 : CW'(rp_inc);
	assign ring_rd_pic = ring_rdata[RW-1 -: PW];

	always_comb begin
		state_d        = state_q;
		rp_d           = rp_q;
		cnt_d          = cnt_q;
		drop_d         = drop_q;
		fin            = 1'b0;
		status_d       = dfrq_pkg::ST_OK;
		opic_d         = '0;
		opay_d         = '0;
		ostate_d       = dfrq_pkg::PIC_FREE;
		ring_we        = 1'b0;
		ring_re        = in_fire;
		ring_raddr     = AW'(rp_q);
		flag_req       = '0;
		flag_req.clear = cfg_fire;
		flag_req.re    = in_fire;
		flag_req.raddr = pic_index;
		flag_req.wdata = dfrq_pkg::PIC_FREE;

		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = S_EXEC;
					drop_d  = '0;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					unique case (act_q)
						dfrq_pkg::ACT_ENQ: begin
							fin = 1'b1;
							if (!pic_ok) begin
								status_d = dfrq_pkg::ST_MISSING;
							end else if (cnt_q >= live) begin
								status_d = dfrq_pkg::ST_FULL;
							end else begin
								ring_we        = 1'b1;
								flag_req.we    = 1'b1;
								flag_req.waddr = pic_q;
								flag_req.wdata = dfrq_pkg::PIC_QUEUED;
								cnt_d          = cnt_q + CW'(1);
							end
						end
						dfrq_pkg::ACT_DEQ: begin
							fin = 1'b1;
							if (cnt_q == '0) begin
								status_d = dfrq_pkg::ST_EMPTY;
							end else begin
								opic_d         = ring_rd_pic;
								opay_d         = ring_rdata[PAYLOAD_BITS-1:0];
								flag_req.we    = 1'b1;
								flag_req.waddr = ring_rd_pic;
								flag_req.wdata = dfrq_pkg::PIC_SHOWN;
								rp_d           = rp_next;
								cnt_d          = cnt_q - CW'(1);
							end
						end
						dfrq_pkg::ACT_DROP: begin
							if (!pic_ok || flag_rdata != dfrq_pkg::PIC_QUEUED) begin
								fin      = 1'b1;
								status_d = dfrq_pkg::ST_MISSING;
							end else begin
								state_d = S_WALK;
							end
						end
						dfrq_pkg::ACT_QUERY: begin
							fin = 1'b1;
							if (!pic_ok) begin
								status_d = dfrq_pkg::ST_MISSING;
							end else begin
								ostate_d = flag_rdata;
							end
						end
					endcase
				end
			end
			S_WALK: begin
				if (out_free) begin
					if (cnt_q == '0) begin
						fin      = 1'b1;
						status_d = dfrq_pkg::ST_MISSING;
					end else begin
						flag_req.we    = 1'b1;
						flag_req.waddr = ring_rd_pic;
						flag_req.wdata = dfrq_pkg::PIC_FREE;
						rp_d           = rp_next;
						cnt_d          = cnt_q - CW'(1);
						drop_d         = drop_q + CW'(1);
						if (ring_rd_pic == pic_q) begin
							fin = 1'b1;
						end else if (cnt_q == CW'(1)) begin
							fin      = 1'b1;
							status_d = dfrq_pkg::ST_MISSING;
						end else begin
							ring_re    = 1'b1;
							ring_raddr = AW'(rp_next);
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= dfrq_pkg::DEPTH_RESET;
			rp_q        <= '0;
			cnt_q       <= '0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			drop_q  <= drop_d;
			if (cfg_fire) begin
				depth_q <= cfg_data;
				rp_q    <= '0;
				cnt_q   <= '0;
			end else begin
				rp_q  <= rp_d;
				cnt_q <= cnt_d;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q <= dfrq_pkg::action_t'(action);
			pic_q <= pic_index;
			pay_q <= payload;
		end
		if (fin) begin
			status_q  <= status_d;
			opic_q    <= opic_d;
			opay_q    <= opay_d;
			ostate_q  <= ostate_d;
			frames_q  <= cnt_d;
			dropped_q <= drop_d;
		end
	end

	dfrq_ring_mem #(
		.DEPTH (MAX_DEPTH),
		.WIDTH (RW)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (AW'(wa)),
		.wdata ({pic_q, pay_q}),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	dfrq_flag_mem u_flags (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (flag_req),
		.rdata  (flag_rdata)
	);

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign out_picture_index = opic_q;
	assign out_payload       = opay_q;
	assign picture_state     = ostate_q;
	assign frames_in_queue   = frames_q;
	assign dropped_count     = dropped_q;

endmodule
